// ===== rtl/dpbp_pkg.sv =====
package dpbp_pkg;

	localparam int unsigned MAX_ROW_WIDTH = 4096;
	localparam int unsigned QDEPTH        = 4;
	localparam int unsigned QPTR_W        = $clog2(QDEPTH);
	localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		REG_BYTES_PER_SAMPLE = 2'd0,
		REG_SAMPLE_BITS      = 2'd1,
		REG_ROW_WIDTH        = 2'd2,
		REG_PREDICTOR_ENABLE = 2'd3
	} dpbp_reg_t;

	typedef struct packed {
		logic [31:0] sample;
		logic        plane_end;
	} dpbp_in_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_byte;
		logic       stream_end;
	} dpbp_out_t;

	typedef struct packed {
		logic [2:0]  bytes_per_sample;
		logic [5:0]  sample_bits;
		logic [12:0] row_width;
		logic        predictor_enable;
	} dpbp_cfg_t;

	// One classified sample: value already differenced (when the predictor applies) and masked to nbits.
	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  nbits;
		logic        flush;
	} dpbp_work_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} dpbp_qstat_t;

endpackage

// ===== rtl/dpbp_front.sv =====
module dpbp_front import dpbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  dpbp_in_t   item,
	input  logic       q_full,
	output logic       q_push,
	output dpbp_work_t q_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [12:0] cfg_data
);

	dpbp_cfg_t   cfg_q;
	logic [31:0] prev_q;
	logic [11:0] col_q;

	logic [5:0]  cbits;
	logic [31:0] cmask;
	logic [31:0] sample_m;
	logic [5:0]  nb;
	logic [12:0] effw;
	logic [11:0] col_cur;
	logic [11:0] col_inc;
	logic [11:0] col_nxt;
	logic [31:0] diff;
	logic [31:0] v;
	logic [31:0] vmask;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;

	always_comb begin
		case (cfg_q.bytes_per_sample) inside
			3'd0, 3'd1: begin
				cbits = 6'd8;
				cmask = 32'h0000_00FF;
			end
			3'd2: begin
				cbits = 6'd16;
				cmask = 32'h0000_FFFF;
			end
			default: begin
				cbits = 6'd32;
				cmask = 32'hFFFF_FFFF;
			end
		endcase

		if (cfg_q.sample_bits == 6'd0) begin
			nb = 6'd1;
		end else if (cfg_q.sample_bits > cbits) begin
			nb = cbits;
		end else begin
			nb = cfg_q.sample_bits;
		end

		if (cfg_q.row_width == 13'd0) begin
			effw = 13'd1;
		end else if (cfg_q.row_width > 13'(MAX_ROW_WIDTH)) begin
			effw = 13'(MAX_ROW_WIDTH);
		end else begin
			effw = cfg_q.row_width;
		end

		sample_m = item.sample & cmask;
		col_cur  = ({1'b0, col_q} >= effw) ? 12'd0 : col_q;
		col_inc  = col_cur + 12'd1;
		col_nxt  = ({1'b0, col_inc} >= effw) ? 12'd0 : col_inc;
		diff     = (sample_m - prev_q) & cmask;
		v        = (cfg_q.predictor_enable && col_cur != 12'd0) ? diff : sample_m;
		vmask    = 32'hFFFF_FFFF >> (6'd32 - nb);

		q_data.value = v & vmask;
		q_data.nbits = nb;
		q_data.flush = item.plane_end;
		q_push       = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_sample <= 3'd1;
			cfg_q.sample_bits      <= 6'd8;
			cfg_q.row_width        <= 13'd1;
			cfg_q.predictor_enable <= 1'b0;
			prev_q                 <= '0;
			col_q                  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (dpbp_reg_t'(cfg_index))
					REG_BYTES_PER_SAMPLE: cfg_q.bytes_per_sample <= cfg_data[2:0];
					REG_SAMPLE_BITS:      cfg_q.sample_bits      <= cfg_data[5:0];
					REG_ROW_WIDTH:        cfg_q.row_width        <= cfg_data;
					REG_PREDICTOR_ENABLE: cfg_q.predictor_enable <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				if (item.plane_end) begin
					prev_q <= '0;
					col_q  <= '0;
				end else begin
					prev_q <= sample_m;
					col_q  <= col_nxt;
				end
			end
		end
	end

endmodule

// ===== rtl/dpbp_queue.sv =====
module dpbp_queue import dpbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  dpbp_work_t  wr_data,
	input  logic        rd_en,
	output dpbp_work_t  rd_data,
	output dpbp_qstat_t stat
);

	dpbp_work_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.full     = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.nonempty = (cnt_q != '0);
	assign do_wr         = wr_en && !stat.full;
	assign do_rd         = rd_en && stat.nonempty;
	assign rd_data       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a write");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == QCNT_W'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/dpbp_back.sv =====
module dpbp_back import dpbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  dpbp_work_t q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output dpbp_out_t  result
);

	logic        act_q;
	logic [39:0] win_q;
	logic [5:0]  cnt_q;
	logic        end_q;
	logic [7:0]  partial_q;
	logic [2:0]  bp_q;
	logic        ovalid_q;
	dpbp_out_t   obuf_q;

	logic        out_space;
	logic        is_full;
	logic        need_emit;
	logic        stepping;
	logic        done;
	logic        finish;
	logic        emit_go;
	logic [5:0]  rem;
	logic [7:0]  part_nxt;
	logic [2:0]  bp_nxt;
	logic [7:0]  part_src;
	logic [2:0]  bp_src;
	logic [31:0] v_left;
	logic [39:0] win_load;
	logic        load;

	assign empty     = !ovalid_q;
	assign result    = obuf_q;
	assign out_space = !ovalid_q || pop;

	always_comb begin
		is_full   = (cnt_q >= 6'd8);
		rem       = is_full ? (cnt_q - 6'd8) : 6'd0;
		need_emit = is_full || (end_q && cnt_q != 6'd0);
		stepping  = act_q && (!need_emit || out_space);
		done      = is_full ? (rem < 6'd8 && !(end_q && rem != 6'd0)) : 1'b1;
		finish    = stepping && done;
		emit_go   = stepping && need_emit;

		if (end_q) begin
			part_nxt = 8'd0;
			bp_nxt   = 3'd0;
		end else if (is_full) begin
			part_nxt = win_q[31:24];
			bp_nxt   = rem[2:0];
		end else begin
			part_nxt = win_q[39:32];
			bp_nxt   = cnt_q[2:0];
		end

		part_src = finish ? part_nxt : partial_q;
		bp_src   = finish ? bp_nxt : bp_q;
		load     = q_nonempty && (!act_q || finish);
		q_pop    = load;

		// left-align the sample bits, then append behind the pending bits
		v_left   = q_data.value << (5'(6'd32 - q_data.nbits));
		win_load = {part_src, 32'd0} | ({v_left, 8'd0} >> bp_src);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			cnt_q     <= '0;
			end_q     <= 1'b0;
			partial_q <= '0;
			bp_q      <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (finish) begin
				partial_q <= part_nxt;
				bp_q      <= bp_nxt;
			end
			if (load) begin
				act_q <= 1'b1;
				cnt_q <= {3'd0, bp_src} + q_data.nbits;
				end_q <= q_data.flush;
			end else if (finish) begin
				act_q <= 1'b0;
			end else if (emit_go) begin
				cnt_q <= rem;
			end
			if (emit_go) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			win_q <= win_load;
		end else if (emit_go) begin
			win_q <= {win_q[31:0], 8'd0};
		end
		if (emit_go) begin
			obuf_q.packed_byte <= win_q[39:32];
			obuf_q.last_byte   <= done;
			obuf_q.stream_end  <= done && end_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> cnt_q <= 6'd39)
		else $error("bit count out of range");

	a_pad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q & (8'hFF >> bp_q)) == 8'd0)
		else $error("partial byte holds bits past its fill point");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && end_q) |=> (bp_q == 3'd0 && partial_q == 8'd0))
		else $error("plane end left pending bits");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && done && end_q) |=> (obuf_q.last_byte && obuf_q.stream_end))
		else $error("plane end byte not marked");
`endif

endmodule

// ===== rtl/diff_predict_bit_packer_unit.sv =====
// Horizontal-difference predictor with MSB-first bit packer. Push one sample per
// transfer; packed bytes come out in order on the result side, one byte per cycle
// while pop is held. The front classifies each sample (difference, mask, bit
// count) and writes it into a four-entry queue; the packer drains the queue one
// output byte per cycle while pop is held, and loads the next item only as it
// finishes the current one (up to five bytes per item, four on average
// for 32-bit samples). Write the register file via cfg_valid/cfg_ready only while
// the block is idle; the block does not enforce this. cfg_ready is always high.
module diff_predict_bit_packer_unit import dpbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  dpbp_in_t    item,
	output logic        empty,
	input  logic        pop,
	output dpbp_out_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	logic        q_push;
	logic        q_pop;
	dpbp_work_t  q_wdata;
	dpbp_work_t  q_rdata;
	dpbp_qstat_t q_stat;

	assign full = q_stat.full;

	dpbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.q_full    (q_stat.full),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dpbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.stat    (q_stat)
	);

	dpbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_stat.nonempty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== verif/tb_diff_predict_bit_packer_unit.sv =====
module tb_diff_predict_bit_packer_unit import dpbp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	dpbp_in_t    item = '0;
	logic        empty;
	logic        pop = 1'b0;
	dpbp_out_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_BYTES_PER_SAMPLE;
	logic [12:0] cfg_data = '0;

	diff_predict_bit_packer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dpbp_in_t  sample_queue[$];
	dpbp_out_t expected_bytes[$];

	logic [2:0]  bytes_per_sample_reg = 3'd1;
	logic [5:0]  sample_bits_reg = 6'd8;
	logic [12:0] row_width_reg = 13'd1;
	logic        predictor_reg = 1'b0;

	logic [31:0] prev_pixel = '0;
	int unsigned column = 0;
	logic [7:0]  byte_acc = '0;
	int unsigned byte_fill = 0;

	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	bit          calm = 1'b0;
	logic [31:0] walk = '0;

	task automatic predict_packed_bytes(input dpbp_in_t it);
		int unsigned cbits;
		int unsigned nb;
		int unsigned w;
		int unsigned k;
		logic [31:0] cmask;
		logic [31:0] s;
		logic [31:0] v;
		dpbp_out_t   ob;
		dpbp_out_t   burst[$];
		cbits = (bytes_per_sample_reg <= 3'd1) ? 8 : (bytes_per_sample_reg == 3'd2) ? 16 : 32;
		cmask = (cbits == 32) ? 32'hFFFF_FFFF : (32'd1 << cbits) - 32'd1;
		s = it.sample & cmask;
		nb = (sample_bits_reg == 6'd0) ? 1 : sample_bits_reg;
		if (nb > cbits)
			nb = cbits;
		w = (row_width_reg == 13'd0) ? 1 :
			(row_width_reg > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width_reg;
		if (column >= w)
			column = 0;
		if (predictor_reg && column != 0)
			v = (s - prev_pixel) & cmask;
		else
			v = s;
		prev_pixel = s;
		column = (column + 1) & 32'hFFF;
		if (column >= w)
			column = 0;
		if (nb < 32)
			v = v & ((32'd1 << nb) - 32'd1);
		for (k = nb; k > 0; k--) begin
			byte_acc[7 - byte_fill] = v[k - 1];
			byte_fill++;
			if (byte_fill == 8) begin
				ob = '{packed_byte: byte_acc, last_byte: 1'b0, stream_end: 1'b0};
				burst.push_back(ob);
				byte_acc = '0;
				byte_fill = 0;
			end
		end
		if (it.plane_end) begin
			if (byte_fill != 0) begin
				ob = '{packed_byte: byte_acc, last_byte: 1'b0, stream_end: 1'b0};
				burst.push_back(ob);
			end
			byte_acc = '0;
			byte_fill = 0;
			column = 0;
			prev_pixel = '0;
		end
		if (burst.size() > 0) begin
			burst[burst.size() - 1].last_byte = 1'b1;
			burst[burst.size() - 1].stream_end = it.plane_end;
		end
		foreach (burst[i])
			expected_bytes.push_back(burst[i]);
	endtask

	// sender: hold push until the transfer, then advance
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				predict_packed_bytes(item);
			if (push && full) begin
				push <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (sample_queue.size() == 0) begin
				push <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 14) - 1;
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				item <= sample_queue.pop_front();
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		dpbp_out_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte expected none actual %h/%b/%b", $time,
						result.packed_byte, result.last_byte, result.stream_end);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (result.packed_byte !== want.packed_byte) begin
						$display("%0t: packed_byte expected %h actual %h", $time,
							want.packed_byte, result.packed_byte);
						errors++;
					end
					if (result.last_byte !== want.last_byte) begin
						$display("%0t: last_byte expected %b actual %b", $time,
							want.last_byte, result.last_byte);
						errors++;
					end
					if (result.stream_end !== want.stream_end) begin
						$display("%0t: stream_end expected %b actual %b", $time,
							want.stream_end, result.stream_end);
						errors++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(1, 14) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input dpbp_reg_t idx, input logic [12:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BYTES_PER_SAMPLE: bytes_per_sample_reg = val[2:0];
			REG_SAMPLE_BITS:      sample_bits_reg = val[5:0];
			REG_ROW_WIDTH:        row_width_reg = val[12:0];
			REG_PREDICTOR_ENABLE: predictor_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic set_format(input logic [12:0] bps, input logic [12:0] nbits,
		input logic [12:0] width, input logic [12:0] pred);
		write_reg(REG_BYTES_PER_SAMPLE, bps);
		write_reg(REG_SAMPLE_BITS, nbits);
		write_reg(REG_ROW_WIDTH, width);
		write_reg(REG_PREDICTOR_ENABLE, pred);
	endtask

	task automatic send(input logic [31:0] s, input logic last);
		dpbp_in_t it;
		it.sample = s;
		it.plane_end = last;
		sample_queue.push_back(it);
	endtask

	// hold the sender until every byte is back and the packer is quiet
	task automatic drain;
		while (sample_queue.size() != 0 || push || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_format;
		int unsigned eff;
		logic [12:0] bps;
		logic [12:0] nbits;
		logic [12:0] width;
		case ($urandom_range(0, 9))
			0, 1, 2: bps = 13'd1;
			3, 4, 5: bps = 13'd2;
			6, 7:    bps = 13'd4;
			8:       bps = 13'd0;
			default: bps = 13'($urandom_range(3, 7));
		endcase
		eff = (bps <= 1) ? 8 : (bps == 2) ? 16 : 32;
		case ($urandom_range(0, 5))
			0:       nbits = 13'(eff);
			1:       nbits = 13'($urandom_range(1, eff));
			2:       nbits = 13'($urandom_range(1, 8));
			3:       nbits = $urandom_range(0, 1) ? 13'd0 : 13'd63;
			default: nbits = 13'($urandom_range(1, 40));
		endcase
		case ($urandom_range(0, 7))
			0, 1, 2, 3, 4: width = 13'($urandom_range(1, 6));
			5:             width = 13'($urandom_range(7, 64));
			6: begin
				case ($urandom_range(0, 3))
					0:       width = 13'd0;
					1:       width = 13'd4096;
					2:       width = 13'd4095;
					default: width = 13'd8191;
				endcase
			end
			default:       width = 13'($urandom_range(0, 8191));
		endcase
		set_format(bps, nbits, width, 13'($urandom_range(0, 1)));
	endtask

	task automatic random_samples(input int unsigned count);
		logic [31:0] s;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0, 1, 2: s = $urandom;
				3, 4, 5: s = walk + $urandom_range(0, 8) - 32'd4;
				6:       s = walk ^ (32'd1 << $urandom_range(0, 31));
				default: s = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			endcase
			walk = s;
			send(s, $urandom_range(0, 11) == 0);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(32'h0000_0000, 1'b0);
		send(32'hFFFF_FFFF, 1'b0);
		send(32'h1234_56A5, 1'b1);
		drain();

		set_format(13'd4, 13'd32, 13'd3, 13'd1);
		send(32'hFFFF_FFFF, 1'b0);
		send(32'h0000_0000, 1'b0);
		send(32'h8000_0001, 1'b0);
		send(32'h7FFF_FFFF, 1'b0);
		send(32'h0000_0000, 1'b1);
		drain();

		set_format(13'd0, 13'd3, 13'd8191, 13'd0);
		send(32'h0000_0007, 1'b0);
		send(32'h0000_0002, 1'b0);
		send(32'hFFFF_FFFD, 1'b0);
		drain();

		set_format(13'd3, 13'd40, 13'd2, 13'd1);
		send(32'hDEAD_BEEF, 1'b1);
		send(32'h0000_0001, 1'b0);
		send(32'h0000_0000, 1'b1);
		drain();

		set_format(13'd2, 13'd0, 13'd0, 13'd1);
		send(32'h0000_0001, 1'b0);
		send(32'h0001_0000, 1'b0);
		send(32'h0000_0001, 1'b1);
		drain();

		set_format(13'd2, 13'd16, 13'd4, 13'd1);
		send(32'h0000_FFFF, 1'b0);
		send(32'h0000_0000, 1'b0);
		send(32'hABCD_1234, 1'b0);
		drain();

		set_format(13'd7, 13'd13, 13'd2, 13'd1);
		send(32'h5555_AAAA, 1'b0);
		send(32'hAAAA_5555, 1'b1);
		drain();

		for (int p = 0; p < 7; p++) begin
			calm = (p % 3 == 2) || (p == 6);
			random_format();
			random_samples(30);
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
